/* hw/rtl/pips_pkg.sv */
// Shared codes and widths of the point-in-polygon set tester.
`default_nettype none

package pips_pkg;

	localparam int KIND_W = 2;
	localparam int RES_W  = 8;

	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic status;
		logic inside_res;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/point_in_polygon_set_test.sv */
// Point-in-polygon tester over a set of stored polygons, with exact ray casting.
// Load, clear and unused kinds go from the EXEC state straight to the DONE state.
// A query walks the stored vertices of every closed polygon, then forms its result:
// one stored vertex is read per cycle, with reads paused while each polygon's closing edge is formed.
// One item is in work at a time; the next transfer is taken while a result waits at the output.
// The asynchronous reset empties the store; vertex memory contents are not cleared.
`default_nettype none

module point_in_polygon_set_test
	import pips_pkg::*;
#(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_WIDTH  = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// coord_x, coord_y, zero padding
	input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	// kind
	input  wire logic [KIND_W-1:0] s_tuser,
	input  wire logic s_tlast,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// inside_res, status, zero padding
	output logic [RES_W-1:0] m_tdata
);

	localparam int CW   = COORD_WIDTH;
	localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNTW = $clog2(MAX_VERTICES + 1);
	localparam int PW   = 2 * CW + 2;
	localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_VERTICES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;

	logic [KIND_W-1:0]  kind_q;
	logic signed [CW-1:0] px_q;
	logic signed [CW-1:0] py_q;
	logic               last_q;

	logic [CNTW-1:0] stored_q;
	logic [CNTW-1:0] closed_q;
	logic [CNTW-1:0] rd_idx_q;

	logic [2*CW:0] vmem_q [MAX_VERTICES];
	logic [2*CW:0] rd_data_s1;
	logic          val_s1;

	logic close_q;
	logic pfirst_q;
	logic signed [CW-1:0] prev_x_q;
	logic signed [CW-1:0] prev_y_q;
	logic signed [CW-1:0] first_x_q;
	logic signed [CW-1:0] first_y_q;

	logic              v_s2;
	logic              end_s2;
	logic              cross_s2;
	logic              den_s2;
	logic signed [CW:0] dsx_s2;
	logic signed [CW:0] dty_s2;
	logic signed [CW:0] dsy_s2;
	logic signed [CW:0] dtx_s2;

	logic              v_s3;
	logic              end_s3;
	logic              cross_s3;
	logic              den_s3;
	logic signed [PW-1:0] a_s3;
	logic signed [PW-1:0] b_s3;

	logic    parity_q;
	logic    hit_q;
	result_t res_q;
	logic    m_tvalid_q;
	result_t m_res_q;

	logic signed [CW-1:0] cur_x;
	logic signed [CW-1:0] cur_y;
	logic                 cur_e;
	logic signed [CW-1:0] sx;
	logic signed [CW-1:0] sy;
	logic signed [CW-1:0] tx;
	logic signed [CW-1:0] ty;
	logic                 edge_vld;
	logic                 issue;
	logic                 close_req;
	logic                 eq_hit;
	logic                 edge_hit;
	logic                 parity_nx;
	logic                 walk_done;
	logic                 wr_en;
	logic                 out_free;
	logic                 in_xfer;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(RES_W-2){1'b0}}, m_res_q.status, m_res_q.inside_res};
	assign out_free = !m_tvalid_q || m_tready;

	assign cur_x = rd_data_s1[CW-1:0];
	assign cur_y = rd_data_s1[2*CW-1:CW];
	assign cur_e = rd_data_s1[2*CW];

	assign wr_en = (state_q == ST_EXEC) && (kind_q == KIND_LOAD) && (stored_q != MAX_CNT);
	assign issue = (state_q == ST_WALK) && (rd_idx_q != closed_q);
	assign close_req = val_s1 && cur_e;
	assign eq_hit = val_s1 && (cur_x == px_q) && (cur_y == py_q);

	// The closing edge runs from the last vertex back to the first one.
	always_comb begin
		if (close_q) begin
			sx = prev_x_q;
			sy = prev_y_q;
			tx = first_x_q;
			ty = first_y_q;
		end else begin
			sx = cur_x;
			sy = cur_y;
			tx = prev_x_q;
			ty = prev_y_q;
		end
	end
	assign edge_vld = close_q || (val_s1 && !pfirst_q);

	assign edge_hit  = v_s3 && cross_s3 && (a_s3 == b_s3);
	assign parity_nx = parity_q ^ (v_s3 && cross_s3 && (a_s3 != b_s3)
		&& ((a_s3 > b_s3) == den_s3));
	assign walk_done = (rd_idx_q == closed_q) && !val_s1 && !close_q && !v_s2 && !v_s3;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vmem_q[stored_q[AW-1:0]] <= {last_q, py_q, px_q};
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= vmem_q[rd_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q <= s_tuser;
			px_q   <= s_tdata[CW-1:0];
			py_q   <= s_tdata[2*CW-1:CW];
			last_q <= s_tlast;
		end
		if (val_s1) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end
		if (val_s1 && pfirst_q) begin
			first_x_q <= cur_x;
			first_y_q <= cur_y;
		end
		end_s2   <= close_q;
		cross_s2 <= (sy < py_q) != (ty < py_q);
		den_s2   <= ty > sy;
		dsx_s2   <= {sx[CW-1], sx} - {px_q[CW-1], px_q};
		dty_s2   <= {ty[CW-1], ty} - {sy[CW-1], sy};
		dsy_s2   <= {sy[CW-1], sy} - {py_q[CW-1], py_q};
		dtx_s2   <= {tx[CW-1], tx} - {sx[CW-1], sx};
		end_s3   <= end_s2;
		cross_s3 <= cross_s2;
		den_s3   <= den_s2;
		a_s3     <= PW'(dsx_s2) * PW'(dty_s2);
		b_s3     <= PW'(dsy_s2) * PW'(dtx_s2);
		if (state_q == ST_WALK && walk_done) begin
			res_q.inside_res <= hit_q;
			res_q.status     <= 1'b0;
		end else if (state_q == ST_EXEC && kind_q != KIND_QUERY) begin
			res_q.inside_res <= 1'b0;
			res_q.status     <= (kind_q == KIND_LOAD) && (stored_q == MAX_CNT);
		end
		if (state_q == ST_DONE && out_free) begin
			m_res_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			stored_q   <= '0;
			closed_q   <= '0;
			rd_idx_q   <= '0;
			val_s1     <= 1'b0;
			close_q    <= 1'b0;
			pfirst_q   <= 1'b1;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			parity_q   <= 1'b0;
			hit_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			val_s1  <= issue && !close_req;
			close_q <= close_req;
			v_s2    <= edge_vld;
			v_s3    <= v_s2;
			if (val_s1) begin
				pfirst_q <= cur_e;
			end
			if (issue && !close_req) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			hit_q <= (state_q == ST_EXEC) ? 1'b0
				: (hit_q | eq_hit | edge_hit | (v_s3 && end_s3 && parity_nx));
			parity_q <= (state_q == ST_EXEC || (v_s3 && end_s3)) ? 1'b0 : parity_nx;
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= (kind_q == KIND_QUERY) ? ST_WALK : ST_DONE;
					unique case (kind_q)
						KIND_LOAD: begin
							if (wr_en) begin
								stored_q <= stored_q + 1'b1;
								if (last_q) begin
									closed_q <= stored_q + 1'b1;
								end
							end
						end
						KIND_QUERY: begin
							rd_idx_q <= '0;
							pfirst_q <= 1'b1;
						end
						KIND_CLEAR: begin
							stored_q <= '0;
							closed_q <= '0;
						end
						default: begin
						end
					endcase
				end
				ST_WALK: begin
					if (walk_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pips_checker.sv */
// Port checker of the point-in-polygon set tester and its bind to the top level.
`default_nettype none

module pips_checker #(
	parameter int TDATA_W = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [TDATA_W-1:0] s_tdata,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [7:0] m_tdata
);

	// A result that is held back keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A result never reports a hit and a dropped vertex together.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("inside and dropped flags both set");

	// The block takes one item at a time, so it is busy after each input transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// Padding bits of a result are always zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:2] == 6'd0))
		else $error("result padding not zero");

endmodule

bind point_in_polygon_set_test pips_checker #(
	.TDATA_W(((2*COORD_WIDTH+7)/8)*8)
) u_pips_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench of the point-in-polygon set tester, driven on its stream ports.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pips_pkg::*;

	localparam int MAX_VERTS = 256;
	localparam int CW = 16;
	localparam int TDATA_W = ((2*CW+7)/8)*8;
	localparam int CMAX = 2**(CW-1) - 1;
	localparam int CMIN = -(2**(CW-1));
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int TOTAL_ITEMS = 1950;
	localparam longint CYCLE_LIMIT = 5000000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = 600;
	localparam int MAX_REPORTS = 10;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		coord_t x;
		coord_t y;
		logic closes;
		logic known;
		result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// coord_x, coord_y, zero padding
	logic [TDATA_W-1:0] s_tdata = '0;
	// kind
	logic [KIND_W-1:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// inside_res, status, zero padding
	logic [RES_W-1:0] m_tdata;

	coord_t vx_mem [MAX_VERTS];
	coord_t vy_mem [MAX_VERTS];
	logic end_mem [MAX_VERTS];
	int n_stored = 0;
	int n_closed = 0;

	result_t expected_q [$];
	stim_row_t directed_rows [$];
	int mismatches = 0;
	int results_seen = 0;
	int counted_items = 0;
	int hold_request = 0;
	bit no_idle = 1'b0;
	longint cycles = 0;

	point_in_polygon_set_test #(
		.MAX_VERTICES(MAX_VERTS),
		.COORD_WIDTH(CW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	function automatic coord_t clip(int v);
		if (v > CMAX)
			return coord_t'(CMAX);
		if (v < CMIN)
			return coord_t'(CMIN);
		return coord_t'(v);
	endfunction

	function automatic bit polygon_covers(int first, int last, coord_t px, coord_t py);
		longint sx, sy, tx, ty, a, b;
		int prev, i;
		bit parity;
		parity = 1'b0;
		prev = last;
		for (i = first; i <= last; i++) begin
			sx = vx_mem[i];
			sy = vy_mem[i];
			tx = vx_mem[prev];
			ty = vy_mem[prev];
			prev = i;
			if (sx == px && sy == py)
				return 1'b1;
			if ((sy < py && ty >= py) || (sy >= py && ty < py)) begin
				a = (sx - px) * (ty - sy);
				b = (sy - py) * (tx - sx);
				if (a == b)
					return 1'b1;
				if ((a > b) == (ty > sy))
					parity = ~parity;
			end
		end
		return parity;
	endfunction

	function automatic result_t pip_apply(logic [KIND_W-1:0] kind, coord_t x, coord_t y,
			logic closes);
		result_t r;
		int first, i;
		r = '0;
		case (kind)
			KIND_LOAD: begin
				if (n_stored < MAX_VERTS) begin
					vx_mem[n_stored] = x;
					vy_mem[n_stored] = y;
					end_mem[n_stored] = closes;
					n_stored++;
					if (closes)
						n_closed = n_stored;
				end else begin
					r.status = 1'b1;
				end
			end
			KIND_QUERY: begin
				first = 0;
				for (i = 0; i < n_closed && !r.inside_res; i++) begin
					if (end_mem[i]) begin
						if (polygon_covers(first, i, x, y))
							r.inside_res = 1'b1;
						first = i + 1;
					end
				end
			end
			KIND_CLEAR: begin
				n_stored = 0;
				n_closed = 0;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic stim_row_t mk_row(logic [KIND_W-1:0] kind, int x, int y, logic closes,
			logic known, logic hit, logic status);
		stim_row_t r;
		r.kind = kind;
		r.x = clip(x);
		r.y = clip(y);
		r.closes = closes;
		r.known = known;
		r.want.inside_res = hit;
		r.want.status = status;
		return r;
	endfunction

	task automatic send_item(logic [KIND_W-1:0] kind, coord_t x, coord_t y, logic closes,
			logic known, result_t want);
		int gap;
		result_t model_res;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		s_tuser <= kind;
		s_tlast <= closes;
		do @(posedge clk); while (!s_tready);
		model_res = pip_apply(kind, x, y, closes);
		expected_q.push_back(known ? want : model_res);
		if (kind != KIND_UNUSED)
			counted_items++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
	endtask

	task automatic send_query(int cx, int cy, int radius);
		int mode, j, qx, qy;
		mode = $urandom_range(0, 9);
		qx = cx + int'($urandom_range(0, 2*radius)) - radius;
		qy = cy + int'($urandom_range(0, 2*radius)) - radius;
		if (mode == 9) begin
			qx = int'(coord_t'($urandom));
			qy = int'(coord_t'($urandom));
		end else if (n_stored > 0 && mode < 2) begin
			j = $urandom_range(0, n_stored - 1);
			qx = vx_mem[j];
			qy = vy_mem[j];
		end else if (n_stored > 1 && mode < 4) begin
			j = $urandom_range(0, n_stored - 2);
			qx = (int'(vx_mem[j]) + int'(vx_mem[j+1])) / 2;
			qy = (int'(vy_mem[j]) + int'(vy_mem[j+1])) / 2;
		end else if (n_stored > 0 && mode == 4) begin
			j = $urandom_range(0, n_stored - 1);
			qy = vy_mem[j];
		end
		send_item(KIND_QUERY, clip(qx), clip(qy), 1'($urandom_range(0, 1)), 1'b0, '0);
	endtask

	task automatic report_mismatch(string what, result_t want, result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s at result %0d: expected inside %0b status %0b, got inside %0b status %0b",
				what, results_seen, want.inside_res, want.status, got.inside_res, got.status);
	endtask

	always @(posedge clk) begin : result_check
		result_t got, want;
		if (m_tvalid && m_tready) begin
			got = result_t'(m_tdata[1:0]);
			if (expected_q.size() == 0) begin
				report_mismatch("Unexpected transfer", '0, got);
			end else begin
				want = expected_q.pop_front();
				if (got.inside_res !== want.inside_res || got.status !== want.status)
					report_mismatch("Mismatch", want, got);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 11);
			stall += hold_request;
			hold_request = 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : stimulus
		int scene_no, fills_done, sel, radius, cx, cy, npoly, nv, v, step, k, n;
		bit grid;
		stim_row_t r;

		directed_rows.push_back(mk_row(KIND_QUERY, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_UNUSED, CMIN, CMAX, 1'b1, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_CLEAR, CMAX, CMIN, 1'b0, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_LOAD, CMIN, CMIN, 1'b0, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_LOAD, CMAX, CMIN, 1'b0, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_LOAD, CMAX, CMAX, 1'b0, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_LOAD, CMIN, CMAX, 1'b1, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_QUERY, CMAX, CMAX, 1'b0, 1'b1, 1'b1, 1'b0));
		directed_rows.push_back(mk_row(KIND_QUERY, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_QUERY, 0, CMIN, 1'b0, 1'b0, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_QUERY, CMIN, 0, 1'b0, 1'b0, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_QUERY, -1, -1, 1'b0, 1'b0, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_CLEAR, 0, 0, 1'b1, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_LOAD, 100, 100, 1'b1, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_QUERY, 100, 100, 1'b0, 1'b1, 1'b1, 1'b0));
		directed_rows.push_back(mk_row(KIND_LOAD, 200, 0, 1'b0, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_LOAD, 200, 400, 1'b1, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_QUERY, 200, 200, 1'b0, 1'b0, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_QUERY, 201, 200, 1'b0, 1'b0, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_LOAD, 1000, 1000, 1'b0, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_LOAD, 2000, 1000, 1'b0, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_LOAD, 1500, 2000, 1'b0, 1'b1, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_QUERY, 1500, 1200, 1'b0, 1'b0, 1'b0, 1'b0));
		directed_rows.push_back(mk_row(KIND_QUERY, 150, 100, 1'b0, 1'b0, 1'b0, 1'b0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			send_item(r.kind, r.x, r.y, r.closes, r.known, r.want);
		end

		scene_no = 0;
		fills_done = 0;
		while (counted_items < TOTAL_ITEMS) begin
			no_idle = ($urandom_range(0, 5) == 0);
			if (scene_no == 0 || $urandom_range(0, 3) == 0)
				drain_results();
			if (scene_no == 10) begin
				no_idle = 1'b1;
				hold_request = LONG_HOLD;
			end
			sel = $urandom_range(0, 99);
			if (scene_no == 2 || (sel >= 72 && sel < 75 && fills_done < 3)) begin
				fills_done++;
				send_item(KIND_CLEAR, clip(0), clip(0), 1'b0, 1'b0, '0);
				cx = int'($urandom_range(0, 20000)) - 10000;
				cy = int'($urandom_range(0, 20000)) - 10000;
				n = MAX_VERTS + $urandom_range(1, 5);
				for (v = 0; v < n; v++)
					send_item(KIND_LOAD,
						clip(cx + int'($urandom_range(0, 4000)) - 2000),
						clip(cy + int'($urandom_range(0, 4000)) - 2000),
						1'($urandom_range(0, 5) == 0 || v == n - 1), 1'b0, '0);
				repeat ($urandom_range(3, 6))
					send_query(cx, cy, 2000);
			end else if (sel < 80) begin
				if (n_stored > 150 || $urandom_range(0, 2) == 0)
					send_item(KIND_CLEAR, clip(0), clip(0), 1'($urandom_range(0, 1)), 1'b0, '0);
				if ($urandom_range(0, 7) == 0) begin
					radius = CMAX;
					cx = 0;
					cy = 0;
				end else begin
					radius = $urandom_range(4, 3000);
					cx = int'($urandom_range(0, 60000)) - 30000;
					cy = int'($urandom_range(0, 60000)) - 30000;
				end
				step = (radius / 4 > 0) ? radius / 4 : 1;
				npoly = $urandom_range(1, 4);
				repeat (npoly) begin
					nv = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
					grid = $urandom_range(0, 1);
					for (v = 0; v < nv; v++) begin
						if (grid)
							send_item(KIND_LOAD,
								clip(cx + (int'($urandom_range(0, 8)) - 4) * step),
								clip(cy + (int'($urandom_range(0, 8)) - 4) * step),
								1'(v == nv - 1), 1'b0, '0);
						else
							send_item(KIND_LOAD,
								clip(cx + int'($urandom_range(0, 2*radius)) - radius),
								clip(cy + int'($urandom_range(0, 2*radius)) - radius),
								1'(v == nv - 1), 1'b0, '0);
						if ($urandom_range(0, 9) == 0)
							send_query(cx, cy, radius);
					end
				end
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 3))
						send_item(KIND_LOAD,
							clip(cx + int'($urandom_range(0, 2*radius)) - radius),
							clip(cy + int'($urandom_range(0, 2*radius)) - radius),
							1'b0, 1'b0, '0);
				repeat ($urandom_range(4, 14))
					send_query(cx, cy, radius);
			end else begin
				repeat ($urandom_range(6, 15)) begin
					k = $urandom_range(0, 9);
					send_item((k < 4) ? KIND_LOAD : (k < 8) ? KIND_QUERY :
						(k == 8) ? KIND_CLEAR : KIND_UNUSED,
						coord_t'($urandom), coord_t'($urandom), 1'($urandom_range(0, 1)),
						1'b0, '0);
				end
			end
			scene_no++;
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
